// ===== rtl/core/cest_pkg.sv =====
// ----------------------------------------------------------------------------
// cest_pkg
// Shared types and constants for the CEST local time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cest_pkg;

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [6:0]  year_in_century;
		logic [26:0] utc_ms;
	} query_t;

	typedef struct packed {
		logic       summer_time;
		logic [4:0] local_hour;
		logic [5:0] local_minute;
		logic [5:0] local_second;
	} result_t;

	localparam logic [26:0] MS_PER_DAY     = 27'd86_400_000;
	localparam logic [26:0] MS_PER_HOUR    = 27'd3_600_000;
	localparam logic [26:0] MS_TWO_HOURS   = 27'd7_200_000;

	localparam logic [3:0]  MONTH_MAR      = 4'd3;
	localparam logic [3:0]  MONTH_OCT      = 4'd10;
	localparam int unsigned MONTHS         = 12;

	// floor(n / 1000) = (n * RECIP_MS) >> 37, exact for n < 2^27
	localparam logic [27:0] RECIP_MS       = 28'd137_438_954;
	// floor(s / 3600) = (s * RECIP_HOUR) >> 29, exact for s < 2^17
	localparam logic [17:0] RECIP_HOUR     = 18'd149_131;
	// floor(r / 60) = (r * RECIP_MIN) >> 18, exact for r < 2^12
	localparam logic [12:0] RECIP_MIN      = 13'd4_370;
	localparam logic [11:0] SEC_PER_HOUR   = 12'd3_600;
	localparam logic [5:0]  SEC_PER_MIN    = 6'd60;

	localparam logic [2:0] MONTH_KEY [MONTHS] = '{
		3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
	};

	// Day of the last Sunday of a 31-day month (Sakamoto weekday of the 31st).
	// Year is 2000 + yy; the 2000 offset terms are folded modulo 7 into the constant.
	function automatic logic [4:0] last_sunday(logic [6:0] yy, logic [3:0] m);
		logic [2:0] key;
		logic [7:0] acc;
		logic [4:0] fold1;
		logic [3:0] fold2;
		logic [2:0] dow;
		key   = (m >= 4'd1 && m <= 4'd12) ? MONTH_KEY[m - 4'd1] : 3'd0;
		acc   = 8'(yy) + 8'(yy[6:2]) + 8'(key) + 8'(yy < 7'd100) + 8'd16;
		fold1 = 5'(acc[2:0]) + 5'(acc[5:3]) + 5'(acc[7:6]);
		fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
		dow   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
		return 5'd31 - 5'(dow);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cest_hms_split.sv =====
// ----------------------------------------------------------------------------
// cest_hms_split
// Splits local milliseconds of the day into hour, minute and second using
// reciprocal multiplies, at most one multiply per stage, with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cest_hms_split (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  tod_valid,
	output logic                 tod_stall,
	input  wire  [26:0]          local_ms,
	input  wire                  summer,
	output logic                 result_valid,
	input  wire                  result_stall,
	output cest_pkg::result_t    result
);
	import cest_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	logic [26:0] ms_s1;
	logic        sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;
	logic [16:0] secs_s2, secs_s3;
	logic [4:0]  hour_s3, hour_s4, hour_s5;
	logic [11:0] rem_s4, rem_s5;
	logic [5:0]  min_s5;

	logic [54:0] ms_prod;
	logic [34:0] hour_prod;
	logic [16:0] hour_secs;
	logic [11:0] rem_c;
	logic [24:0] min_prod;
	logic [11:0] min_secs;
	logic [11:0] sec_c;

	result_t     out_q;
	logic        out_valid_q;

	assign rdy_out   = !out_valid_q || !result_stall;
	assign rdy_s5    = !v_s5 || rdy_out;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign tod_stall = !rdy_s1;

	assign ms_prod   = 55'(ms_s1) * 55'(RECIP_MS);
	assign hour_prod = 35'(secs_s2) * 35'(RECIP_HOUR);
	assign hour_secs = 17'(hour_s3) * 17'(SEC_PER_HOUR);
	assign rem_c     = 12'(secs_s3 - hour_secs);
	assign min_prod  = 25'(rem_s4) * 25'(RECIP_MIN);
	assign min_secs  = 12'(min_s5) * 12'(SEC_PER_MIN);
	assign sec_c     = rem_s5 - min_secs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= tod_valid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_s4)  v_s4        <= v_s3;
			if (rdy_s5)  v_s5        <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && tod_valid) begin
			ms_s1  <= local_ms;
			sum_s1 <= summer;
		end
		if (rdy_s2 && v_s1) begin
			secs_s2 <= ms_prod[53:37];
			sum_s2  <= sum_s1;
		end
		if (rdy_s3 && v_s2) begin
			hour_s3 <= hour_prod[33:29];
			secs_s3 <= secs_s2;
			sum_s3  <= sum_s2;
		end
		if (rdy_s4 && v_s3) begin
			hour_s4 <= hour_s3;
			rem_s4  <= rem_c;
			sum_s4  <= sum_s3;
		end
		if (rdy_s5 && v_s4) begin
			hour_s5 <= hour_s4;
			min_s5  <= min_prod[23:18];
			rem_s5  <= rem_s4;
			sum_s5  <= sum_s4;
		end
		if (rdy_out && v_s5) begin
			out_q.summer_time  <= sum_s5;
			out_q.local_hour   <= hour_s5;
			out_q.local_minute <= min_s5;
			out_q.local_second <= sec_c[5:0];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/cest_local_time_converter.sv =====
// ----------------------------------------------------------------------------
// cest_local_time_converter
// Central European local time (CET/CEST) from a UTC date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   query channel  : query_valid / query_stall, payload query (day, month,
//                    two-digit year, UTC ms since midnight).
//   result channel : result_valid / result_stall, payload result (summer-time
//                    flag, local hour, minute, second).
//   A transfer happens on a rising edge with valid high and stall low.
//   A query passes from its transfer to result valid through nine
//   registers: the input register, two front stages (day wrap and
//   last-Sunday lookup, summer decision and hour offset), five split stages
//   (local day wrap into the first, then one reciprocal multiply or
//   subtract each) and the output register.
//   Throughput is one query per cycle while query_stall is low; every stage
//   is a short single pass. When the receiver stalls, the result holds and
//   the pipeline keeps filling its empty stages; query_stall rises only once
//   every stage holds an item.
//   Reset empties the pipeline; result_valid is low afterwards. Local time
//   wraps at midnight without changing the date.
// ----------------------------------------------------------------------------
`default_nettype none

module cest_local_time_converter (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  query_valid,
	output logic                 query_stall,
	input  cest_pkg::query_t     query,
	output logic                 result_valid,
	input  wire                  result_stall,
	output cest_pkg::result_t    result
);
	import cest_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        rdy_s1, rdy_s2, rdy_s3;
	logic        split_stall;

	query_t      q_s1;
	logic [26:0] ms_s2;
	logic [4:0]  day_s2;
	logic [3:0]  month_s2;
	logic [4:0]  lsun_s2;
	logic [26:0] loc_s3;
	logic        sum_s3;

	logic [26:0] ms_wrap;
	logic        after_one;
	logic        summer_c;
	logic [26:0] loc_raw;
	logic [26:0] loc_wrap;

	assign rdy_s3      = !v_s3 || !split_stall;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign query_stall = !rdy_s1;

	assign ms_wrap = (q_s1.utc_ms >= MS_PER_DAY) ? q_s1.utc_ms - MS_PER_DAY : q_s1.utc_ms;

	assign after_one = ms_s2 >= MS_PER_HOUR;

	always_comb begin
		case (month_s2) inside
			[4'd4:4'd9]: begin
				summer_c = 1'b1;
			end
			MONTH_MAR: begin
				summer_c = (day_s2 > lsun_s2) || ((day_s2 == lsun_s2) && after_one);
			end
			MONTH_OCT: begin
				summer_c = (day_s2 < lsun_s2) || ((day_s2 == lsun_s2) && !after_one);
			end
			default: begin
				summer_c = 1'b0;
			end
		endcase
	end

	assign loc_raw  = ms_s2 + (summer_c ? MS_TWO_HOURS : MS_PER_HOUR);
	assign loc_wrap = (loc_s3 >= MS_PER_DAY) ? loc_s3 - MS_PER_DAY : loc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= query_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && query_valid) begin
			q_s1 <= query;
		end
		if (rdy_s2 && v_s1) begin
			ms_s2    <= ms_wrap;
			day_s2   <= q_s1.day_of_month;
			month_s2 <= q_s1.month_number;
			lsun_s2  <= last_sunday(q_s1.year_in_century, q_s1.month_number);
		end
		if (rdy_s3 && v_s2) begin
			loc_s3 <= loc_raw;
			sum_s3 <= summer_c;
		end
	end

	cest_hms_split u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.tod_valid    (v_s3),
		.tod_stall    (split_stall),
		.local_ms     (loc_wrap),
		.summer       (sum_s3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cest_ltc_checker.sv =====
// ----------------------------------------------------------------------------
// cest_ltc_checker
// Port-level checks for the CEST local time converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cest_ltc_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  query_stall,
	input  wire                  result_valid,
	input  wire                  result_stall,
	input  cest_pkg::result_t    result
);
	import cest_pkg::*;

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// back-pressure only with a full pipe behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> result_valid && result_stall)
		else $error("query stalled without a stalled result");

	// pipeline is empty straight after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid straight after reset");

	// local time fields stay inside one day
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.local_hour < 5'd24) && (result.local_minute < 6'd60)
			&& (result.local_second < 6'd60))
		else $error("local time field out of range");

endmodule

bind cest_local_time_converter cest_ltc_checker u_ltc_checker (.*);

`default_nettype wire

// ===== bench/cest_local_time_converter_tb.sv =====
// ----------------------------------------------------------------------------
// cest_local_time_converter_tb
// Self-checking bench for the CET/CEST local time converter. A directed table
// covers field extremes, the March and October switch-over hour, odd days,
// months and years, and the midnight wrap. Random queries then follow, 45 in
// 100 aimed at the last-Sunday boundaries. Both channels idle at random. Each
// result transfer is checked against the table's value or a behavioural model.
// ----------------------------------------------------------------------------
`default_nettype none

module cest_local_time_converter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cest_pkg::*;

	localparam int          RANDOM_QUERIES = 800;
	localparam int          DRAIN_CYCLES   = 20;
	localparam int          CYCLE_LIMIT    = 200_000;
	localparam int unsigned DAY_MS         = 86_400_000;
	localparam int unsigned HOUR_MS        = 3_600_000;

	typedef struct {
		query_t  q;
		bit      typed;
		result_t want;
	} directed_row_t;

	localparam int N_DIRECTED = 25;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{5'd0,  4'd0,  7'd0,   27'd0},         1'b1, '{1'b0, 5'd1,  6'd0,  6'd0}},
		'{'{5'd31, 4'd15, 7'd127, 27'd134217727}, 1'b1, '{1'b0, 5'd14, 6'd16, 6'd57}},
		'{'{5'd1,  4'd15, 7'd0,   27'd86399999},  1'b1, '{1'b0, 5'd0,  6'd59, 6'd59}},
		'{'{5'd15, 4'd6,  7'd50,  27'd0},         1'b1, '{1'b1, 5'd2,  6'd0,  6'd0}},
		'{'{5'd15, 4'd7,  7'd99,  27'd86399999},  1'b1, '{1'b1, 5'd1,  6'd59, 6'd59}},
		'{'{5'd10, 4'd1,  7'd0,   27'd82800000},  1'b1, '{1'b0, 5'd0,  6'd0,  6'd0}},
		'{'{5'd10, 4'd8,  7'd0,   27'd79200000},  1'b1, '{1'b1, 5'd0,  6'd0,  6'd0}},
		'{'{5'd31, 4'd3,  7'd24,  27'd3599999},   1'b0, '{default: '0}},
		'{'{5'd31, 4'd3,  7'd24,  27'd3600000},   1'b0, '{default: '0}},
		'{'{5'd27, 4'd10, 7'd24,  27'd3599999},   1'b0, '{default: '0}},
		'{'{5'd27, 4'd10, 7'd24,  27'd3600000},   1'b0, '{default: '0}},
		'{'{5'd0,  4'd3,  7'd24,  27'd43200000},  1'b0, '{default: '0}},
		'{'{5'd0,  4'd10, 7'd24,  27'd43200000},  1'b0, '{default: '0}},
		'{'{5'd31, 4'd10, 7'd25,  27'd0},         1'b0, '{default: '0}},
		'{'{5'd30, 4'd3,  7'd25,  27'd3600000},   1'b0, '{default: '0}},
		'{'{5'd29, 4'd3,  7'd100, 27'd3600000},   1'b0, '{default: '0}},
		'{'{5'd28, 4'd10, 7'd127, 27'd0},         1'b0, '{default: '0}},
		'{'{5'd25, 4'd3,  7'd99,  27'd86400000},  1'b0, '{default: '0}},
		'{'{5'd5,  4'd2,  7'd12,  27'd100},       1'b0, '{default: '0}},
		'{'{5'd5,  4'd11, 7'd12,  27'd100},       1'b0, '{default: '0}},
		'{'{5'd1,  4'd12, 7'd0,   27'd86399000},  1'b0, '{default: '0}},
		'{'{5'd20, 4'd4,  7'd0,   27'd1000},      1'b0, '{default: '0}},
		'{'{5'd20, 4'd9,  7'd0,   27'd999},       1'b0, '{default: '0}},
		'{'{5'd31, 4'd13, 7'd64,  27'd67108864},  1'b0, '{default: '0}},
		'{'{5'd17, 4'd3,  7'd31,  27'd123456789}, 1'b0, '{default: '0}}
	};

	logic    clk;
	logic    arst_n;
	logic    query_valid;
	logic    query_stall;
	query_t  query;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t pending_results [$];
	int      mismatch_count;
	int      cycle_count;
	bit      idle_enabled;

	cest_local_time_converter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	function automatic int unsigned last_sunday_day(int unsigned yy, int unsigned month);
		int unsigned month_key [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		int unsigned y;
		y = 2000 + yy;
		return 31 - ((y + y / 4 - y / 100 + y / 400 + month_key[(month - 1) % 12] + 31) % 7);
	endfunction

	function automatic result_t local_time_of(query_t q);
		int unsigned ms;
		int unsigned secs;
		int unsigned sunday;
		bit          summer;
		bit          after_one;
		result_t     r;
		ms        = int'(q.utc_ms) % DAY_MS;
		after_one = ms >= HOUR_MS;
		summer    = 1'b0;
		if (q.month_number > MONTH_MAR && q.month_number < MONTH_OCT) begin
			summer = 1'b1;
		end else if (q.month_number == MONTH_MAR || q.month_number == MONTH_OCT) begin
			sunday = last_sunday_day(q.year_in_century, q.month_number);
			if (q.month_number == MONTH_MAR) begin
				summer = q.day_of_month > sunday || (q.day_of_month == sunday && after_one);
			end else begin
				summer = q.day_of_month < sunday || (q.day_of_month == sunday && !after_one);
			end
		end
		secs           = ((ms + (summer ? 2 * HOUR_MS : HOUR_MS)) / 1000) % 86400;
		r.summer_time  = summer;
		r.local_hour   = 5'(secs / 3600);
		r.local_minute = 6'((secs % 3600) / 60);
		r.local_second = 6'(secs % 60);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result transfer with nothing outstanding: %p", got));
		end else begin
			want = pending_results.pop_front();
			if (got.summer_time !== want.summer_time)
				report_mismatch($sformatf("summer_time %b, want %b",
					got.summer_time, want.summer_time));
			if (got.local_hour !== want.local_hour)
				report_mismatch($sformatf("local_hour %0d, want %0d",
					got.local_hour, want.local_hour));
			if (got.local_minute !== want.local_minute)
				report_mismatch($sformatf("local_minute %0d, want %0d",
					got.local_minute, want.local_minute));
			if (got.local_second !== want.local_second)
				report_mismatch($sformatf("local_second %0d, want %0d",
					got.local_second, want.local_second));
		end
	endtask

	// Called on the edge of the previous transfer; valid stays high unless a gap is taken.
	task automatic send_query(query_t q, bit typed, result_t want);
		if (idle_enabled && $urandom_range(99) < 30) begin
			query_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		query_valid <= 1'b1;
		query       <= q;
		do @(posedge clk); while (query_stall);
		pending_results.push_back(typed ? want : local_time_of(q));
	endtask

	task automatic drain_results();
		query_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cest_local_time_converter regression: fail");
		$finish;
	end

	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) check_result(result);
			result_stall <= idle_enabled && ($urandom_range(99) < 30);
		end
	end

	initial begin
		query_t      q;
		int unsigned sunday;
		int unsigned pick;
		arst_n         = 1'b0;
		query_valid    = 1'b0;
		query          = '0;
		idle_enabled   = 1'b1;
		mismatch_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			idle_enabled = !(i >= 300 && i < 500);
			if (i == 550) drain_results();
			pick = $urandom_range(99);
			if (pick < 45) begin
				// around the switch-over Sunday and hour
				q.month_number    = $urandom_range(1) ? MONTH_MAR : MONTH_OCT;
				q.year_in_century = 7'($urandom_range(0, 99));
				sunday            = last_sunday_day(q.year_in_century, q.month_number);
				case ($urandom_range(3))
					0: q.day_of_month = 5'(sunday - 1);
					1: q.day_of_month = 5'(sunday);
					2: q.day_of_month = 5'((sunday == 31) ? 31 : sunday + 1);
					default: q.day_of_month = 5'($urandom_range(0, 31));
				endcase
				if ($urandom_range(1))
					q.utc_ms = 27'(HOUR_MS + $urandom_range(0, 4) - 2);
				else
					q.utc_ms = 27'($urandom_range(0, DAY_MS - 1));
			end else if (pick < 80) begin
				q.day_of_month    = 5'($urandom_range(1, 31));
				q.month_number    = 4'($urandom_range(1, 12));
				q.year_in_century = 7'($urandom_range(0, 99));
				q.utc_ms          = 27'($urandom_range(0, DAY_MS - 1));
			end else begin
				q = query_t'(43'({$urandom(), $urandom()}));
			end
			send_query(q, 1'b0, '0);
		end

		drain_results();
		idle_enabled = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("cest_local_time_converter regression: pass");
		else
			$display("cest_local_time_converter regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/cest_pkg.sv
rtl/core/cest_hms_split.sv
rtl/core/cest_local_time_converter.sv
rtl/core/cest_ltc_checker.sv
bench/cest_local_time_converter_tb.sv
